FILE: hdl/mrr_pkg.sv
// Shared types, codes and constants for the MIPS REL relocation patcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package mrr_pkg;

    // Default depth of the HI16 pending stack
    localparam int STACK_DEPTH_DEF = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR_ADJUST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_COUNT   = 1'd1;

    // Relocation types
    localparam logic [7:0] RT_NONE = 8'd0;
    localparam logic [7:0] RT_32   = 8'd2;
    localparam logic [7:0] RT_26   = 8'd4;
    localparam logic [7:0] RT_HI16 = 8'd5;
    localparam logic [7:0] RT_LO16 = 8'd6;
    localparam logic [7:0] RT_PC16 = 8'd10;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SYM  = 3'd1;
    localparam logic [2:0] ST_BAD_JUMP = 3'd2;
    localparam logic [2:0] ST_BAD_PAIR = 3'd3;
    localparam logic [2:0] ST_PC16_RNG = 3'd4;
    localparam logic [2:0] ST_BAD_TYPE = 3'd5;

    // Special section indexes
    localparam logic [15:0] SECT_UNDEFINED = 16'h0000;
    localparam logic [15:0] SECT_COMMON    = 16'hfff2;

    // Jump target is taken relative to the delay slot
    localparam logic [31:0] JUMP_STEP = 32'd4;

    // One slot of the HI16 stack
    typedef struct packed {
        logic        valid;
        logic [31:0] loc;
        logic [31:0] val;
        logic [31:0] word;
    } t_slot;

    // Stack operation applied to every cell in the same cycle
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_stack_op;

    // Entry held in the result stage
    typedef struct packed {
        logic        sym_bad;
        logic [7:0]  rtype;
        logic        over;
        logic        pair;
        logic        mismatch;
        logic [31:0] p;
        logic [31:0] w;
        logic [31:0] v;
        logic [31:0] vl;
        logic [3:0]  jt_region;
        logic [31:0] d;
        logic [31:0] hi_loc;
        logic [31:0] hi_word;
    } t_item;

    // One result as presented on the output channel
    typedef struct packed {
        logic        wv;
        logic [31:0] addr;
        logic [31:0] data;
        logic [2:0]  status;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/mrr_stack_cell.sv
// One cell of the HI16 shift stack: holds a slot, shifts on push and pop.
// Depends on mrr_pkg (t_slot, t_stack_op).
`default_nettype none

module mrr_stack_cell
    import mrr_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire t_stack_op i_op,
    input  wire t_slot     i_above,
    input  wire t_slot     i_below,
    output t_slot          o_slot
);

    t_slot r_slot;
    t_slot n_slot;

    // Push takes the neighbor above, pop the one below, clear drops the entry
    always_comb begin
        n_slot = r_slot;
        if (i_op.push) begin
            n_slot = i_above;
        end else if (i_op.pop) begin
            n_slot = i_below;
        end else if (i_op.clear) begin
            n_slot.valid = 1'b0;
        end
    end

    // Only the valid bit is reset; payload follows it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.loc  <= n_slot.loc;
        r_slot.val  <= n_slot.val;
        r_slot.word <= n_slot.word;
    end

    assign o_slot = r_slot;

endmodule

`default_nettype wire

FILE: hdl/mrr_result.sv
// Result formatter: turns a staged entry into the result of the current phase.
// Depends on mrr_pkg (t_item, t_result, type and status codes).
`default_nettype none

module mrr_result
    import mrr_pkg::*;
(
    input  wire t_item i_item,
    input  wire        i_phase,
    output t_result    o_res,
    output logic       o_two
);

    logic [31:0] w_jsum;
    logic [15:0] w_hi;
    logic [31:0] w_sh;
    logic [31:0] w_rel;
    logic        w_fit;

    // Arithmetic for the individual types
    assign w_jsum = i_item.w + {2'b00, i_item.v[31:2]};
    assign w_hi   = i_item.hi_word[15:0] + i_item.vl[31:16] + {15'd0, i_item.vl[15]};
    assign w_sh   = {{2{i_item.d[31]}}, i_item.d[31:2]};
    assign w_rel  = w_sh - 32'd1;
    assign w_fit  = (&w_rel[31:15]) | ~(|w_rel[31:15]);

    // A paired LO16 gives the HI16 write first, then its own
    assign o_two = !i_item.sym_bad && (i_item.rtype == RT_LO16) && i_item.pair;

    always_comb begin
        o_res = '{wv: 1'b0, addr: 32'd0, data: 32'd0, status: ST_OK, last: 1'b1};
        if (i_item.sym_bad) begin
            o_res.status = ST_BAD_SYM;
        end else begin
            case (i_item.rtype)
                RT_NONE: begin
                    o_res.status = ST_OK;
                end
                RT_32: begin
                    o_res.wv   = 1'b1;
                    o_res.addr = i_item.p;
                    o_res.data = i_item.w + i_item.v;
                end
                RT_26: begin
                    if ((i_item.v[1:0] != 2'b00) || (i_item.v[31:28] != i_item.jt_region)) begin
                        o_res.status = ST_BAD_JUMP;
                    end else begin
                        o_res.wv   = 1'b1;
                        o_res.addr = i_item.p;
                        o_res.data = {i_item.w[31:26], w_jsum[25:0]};
                    end
                end
                RT_HI16: begin
                    o_res.status = i_item.over ? ST_BAD_PAIR : ST_OK;
                end
                RT_LO16: begin
                    if (i_item.mismatch) begin
                        o_res.status = ST_BAD_PAIR;
                    end else if (i_item.pair && !i_phase) begin
                        o_res.wv   = 1'b1;
                        o_res.addr = i_item.hi_loc;
                        o_res.data = {i_item.hi_word[31:16], w_hi};
                        o_res.last = 1'b0;
                    end else begin
                        o_res.wv   = 1'b1;
                        o_res.addr = i_item.p;
                        o_res.data = {i_item.w[31:16], i_item.vl[15:0]};
                    end
                end
                RT_PC16: begin
                    if (!w_fit) begin
                        o_res.status = ST_PC16_RNG;
                    end else begin
                        o_res.wv   = 1'b1;
                        o_res.addr = i_item.p;
                        o_res.data = {i_item.w[31:16], w_rel[15:0]};
                    end
                end
                default: begin
                    o_res.status = ST_BAD_TYPE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mips_rel_relocation_patch.sv
// Top level of the MIPS ELF32 REL relocation patcher.
// Depends on mrr_pkg, mrr_stack_cell and mrr_result.
//
//  channel  | valid          | ready          | payload
//  ---------+----------------+----------------+---------------------------------------
//  entry in | i_in_valid     | o_in_ready     | section_start .. target_word
//  write out| o_out_valid    | i_out_ready    | write_valid, address, data, status, last
//  config   | i_cfg_we       | (none)         | i_cfg_index, i_cfg_data
//
// An entry passes an input stage (symbol sum and checks), then a stage that does
// the stack push or pop and the address sums, then the output register. One
// entry per cycle is taken while the output is not stalled; a LO16 that pairs
// with a pending HI16 holds the result stage until both its output words are
// loaded, the HI16 word first.
// Reset clears the stack valid bits directly, no clearing pass. A stalled
// output backs up through the stages to o_in_ready.
`default_nettype none

module mips_rel_relocation_patch
    import mrr_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // configuration
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_index,
    input  wire [31:0]          i_cfg_data,
    // entry request
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire                 i_section_start,
    input  wire [7:0]           i_reloc_type,
    input  wire [23:0]          i_symbol_index,
    input  wire [15:0]          i_symbol_section,
    input  wire [31:0]          i_section_base,
    input  wire [31:0]          i_symbol_offset,
    input  wire [31:0]          i_target_address,
    input  wire [31:0]          i_target_word,
    // write request
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic                o_write_valid,
    output logic [31:0]         o_write_address,
    output logic [31:0]         o_write_data,
    output logic [2:0]          o_status,
    output logic                o_last
);

    // Configuration registers
    logic [31:0] r_adjust;
    logic [15:0] r_sym_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adjust    <= 32'd0;
            r_sym_count <= 16'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ADDR_ADJUST) begin
                r_adjust <= i_cfg_data;
            end else if (i_cfg_index == CFG_SYM_COUNT) begin
                r_sym_count <= i_cfg_data[15:0];
            end
        end
    end

    // Handshake between stages
    logic r_a_valid;
    logic r_b_valid;
    logic r_b_phase;
    logic r_o_valid;
    logic w_in_acc;
    logic w_a_move;
    logic w_b_ready;
    logic w_b_done;
    logic w_o_load;
    logic w_two;

    assign w_o_load   = r_b_valid && (!r_o_valid || i_out_ready);
    assign w_b_done   = w_o_load && (!w_two || r_b_phase);
    assign w_b_ready  = !r_b_valid || w_b_done;
    assign w_a_move   = r_a_valid && w_b_ready;
    assign o_in_ready = !r_a_valid || w_b_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Input stage: symbol sum and symbol checks
    logic        r_a_start;
    logic [7:0]  r_a_type;
    logic        r_a_bad;
    logic [31:0] r_a_s;
    logic [31:0] r_a_p;
    logic [31:0] r_a_w;
    logic        w_in_bad;

    assign w_in_bad = (i_symbol_index >= {8'd0, r_sym_count})
                    || (i_symbol_section == SECT_UNDEFINED)
                    || (i_symbol_section == SECT_COMMON);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_a_valid <= 1'b1;
        end else if (w_a_move) begin
            r_a_valid <= 1'b0;
        end
        if (w_in_acc) begin
            r_a_start <= i_section_start;
            r_a_type  <= i_reloc_type;
            r_a_bad   <= w_in_bad;
            r_a_s     <= i_section_base + i_symbol_offset;
            r_a_p     <= i_target_address;
            r_a_w     <= i_target_word;
        end
    end

    // HI16 stack: a row of cells, top at cell 0
    t_slot     w_slot [STACK_DEPTH];
    t_slot     w_above[STACK_DEPTH];
    t_slot     w_below[STACK_DEPTH];
    t_slot     w_new;
    t_stack_op w_op;
    logic      w_top_valid;
    logic      w_full;
    logic      w_is_hi;
    logic      w_is_lo;

    // A section start empties the stack before the entry is handled
    assign w_top_valid = w_slot[0].valid && !r_a_start;
    assign w_full      = w_slot[STACK_DEPTH-1].valid && !r_a_start;
    assign w_is_hi     = !r_a_bad && (r_a_type == RT_HI16);
    assign w_is_lo     = !r_a_bad && (r_a_type == RT_LO16);

    assign w_op.clear = w_a_move && r_a_start;
    assign w_op.push  = w_a_move && w_is_hi && !w_full;
    assign w_op.pop   = w_a_move && w_is_lo && w_top_valid;

    assign w_new = '{valid: 1'b1, loc: r_a_p, val: r_a_s, word: r_a_w};

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            // Neighbors shifted in are dropped when the stack is cleared
            if (g == 0) begin : g_top
                assign w_above[g] = w_new;
            end else begin : g_mid
                assign w_above[g] = '{valid: w_slot[g-1].valid && !w_op.clear,
                                      loc:   w_slot[g-1].loc,
                                      val:   w_slot[g-1].val,
                                      word:  w_slot[g-1].word};
            end
            if (g == STACK_DEPTH - 1) begin : g_end
                assign w_below[g] = '{valid: 1'b0, loc: 32'd0, val: 32'd0, word: 32'd0};
            end else begin : g_inner
                assign w_below[g] = w_slot[g+1];
            end

            mrr_stack_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (w_op),
                .i_above (w_above[g]),
                .i_below (w_below[g]),
                .o_slot  (w_slot[g])
            );
        end
    endgenerate

    // Result stage: address sums and the popped HI16 entry
    t_item       r_b;
    logic [31:0] w_lo;
    logic        w_match;

    assign w_lo    = {{16{r_a_w[15]}}, r_a_w[15:0]};
    assign w_match = (w_slot[0].val == r_a_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_phase <= 1'b0;
        end else begin
            if (w_a_move) begin
                r_b_valid <= 1'b1;
            end else if (w_b_done) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_done) begin
                r_b_phase <= 1'b0;
            end else if (w_o_load) begin
                r_b_phase <= 1'b1;
            end
        end
        if (w_a_move) begin
            r_b.sym_bad   <= r_a_bad;
            r_b.rtype     <= r_a_type;
            r_b.over      <= w_full;
            r_b.pair      <= w_top_valid && w_match;
            r_b.mismatch  <= w_is_lo && w_top_valid && !w_match;
            r_b.p         <= r_a_p;
            r_b.w         <= r_a_w;
            r_b.v         <= r_a_s + r_adjust;
            r_b.vl        <= r_a_s + r_adjust + w_lo;
            r_b.jt_region <= 4'((r_a_p + r_adjust + JUMP_STEP) >> 28);
            r_b.d         <= r_a_s - r_a_p;
            r_b.hi_loc    <= w_slot[0].loc;
            r_b.hi_word   <= w_slot[0].word;
        end
    end

    // Result formatting
    t_result w_res;

    mrr_result u_result (
        .i_item  (r_b),
        .i_phase (r_b_phase),
        .o_res   (w_res),
        .o_two   (w_two)
    );

    // Output register
    t_result r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
        if (w_o_load) begin
            r_o <= w_res;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_write_valid   = r_o.wv;
    assign o_write_address = r_o.addr;
    assign o_write_data    = r_o.data;
    assign o_status        = r_o.status;
    assign o_last          = r_o.last;

endmodule

`default_nettype wire

FILE: hdl/mrr_checker.sv
// Port-level checks for the relocation patcher, bound to the top level.
// Depends on mrr_pkg (status codes) and mips_rel_relocation_patch.
`default_nettype none

module mrr_checker
    import mrr_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire        o_write_valid,
    input wire [31:0] o_write_address,
    input wire [31:0] o_write_data,
    input wire [2:0]  o_status,
    input wire        o_last
);

    // A stalled write request holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_write_valid)
        && $stable(o_write_address) && $stable(o_write_data) && $stable(o_status)
        && $stable(o_last))
        else $error("write request changed while stalled");

    // A result without a write carries zero address and data
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_valid |-> (o_write_address == 32'd0)
        && (o_write_data == 32'd0))
        else $error("non-write result has nonzero payload");

    // Writes only come with good status
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_valid |-> (o_status == ST_OK))
        else $error("write with error status");

    // Only the HI16 write of a pair is not last, and the LO16 write follows it
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid && o_write_valid && o_last)
        else $error("paired write not followed by its LO16 write");

    // An error result always ends its entry
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_last && !o_write_valid)
        else $error("error result not final");

endmodule

bind mips_rel_relocation_patch mrr_checker u_mrr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_write_valid   (o_write_valid),
    .o_write_address (o_write_address),
    .o_write_data    (o_write_data),
    .o_status        (o_status),
    .o_last          (o_last)
);

`default_nettype wire

FILE: tb/tb_mips_rel_relocation_patch.sv
// Self-checking testbench for mips_rel_relocation_patch: random and directed
// relocation entries, a behavioral patch predictor and an in-order write check.
// Depends on mrr_pkg (types, codes) and the block's top level.
`timescale 1ns / 1ps

module tb_mips_rel_relocation_patch;
    import mrr_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int HI_DEPTH      = STACK_DEPTH_DEF;
    localparam int MAX_WAIT      = 15;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 600000;

    // One relocation entry as offered on the request side
    typedef struct packed {
        logic        start;
        logic [7:0]  rtype;
        logic [23:0] sym;
        logic [15:0] shndx;
        logic [31:0] base;
        logic [31:0] offs;
        logic [31:0] p;
        logic [31:0] w;
    } t_reloc_req;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_section_start;
    logic [7:0]           i_reloc_type;
    logic [23:0]          i_symbol_index;
    logic [15:0]          i_symbol_section;
    logic [31:0]          i_section_base;
    logic [31:0]          i_symbol_offset;
    logic [31:0]          i_target_address;
    logic [31:0]          i_target_word;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_write_valid;
    logic [31:0]          o_write_address;
    logic [31:0]          o_write_data;
    logic [2:0]           o_status;
    logic                 o_last;

    // Request currently offered, and the queue feeding it
    t_reloc_req cur_req = '0;
    t_reloc_req reloc_entries[$];
    t_result    patched_words[$];

    // Register shadows and HI16 stack model
    logic [31:0] addr_adjust = '0;
    logic [15:0] sym_limit = '0;
    logic [31:0] hi_loc  [HI_DEPTH];
    logic [31:0] hi_sym  [HI_DEPTH];
    logic [31:0] hi_word [HI_DEPTH];
    logic        hi_open [HI_DEPTH];
    int          hi_level = 0;

    // Handshake bookkeeping
    int accepted_cnt = 0;
    int tx_done_cnt  = 0;
    int results_cnt  = 0;
    int rx_seen_cnt  = 0;
    int hold_req_cnt = 0;
    int hold_done_cnt = 0;
    int queued_cnt   = 0;
    int fail_cnt     = 0;
    int cycle_cnt    = 0;
    bit tx_busy = 1'b0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int tx_gap  = 0;
    int rx_wait = 0;
    int rx_hold = 0;

    assign i_section_start  = cur_req.start;
    assign i_reloc_type     = cur_req.rtype;
    assign i_symbol_index   = cur_req.sym;
    assign i_symbol_section = cur_req.shndx;
    assign i_section_base   = cur_req.base;
    assign i_symbol_offset  = cur_req.offs;
    assign i_target_address = cur_req.p;
    assign i_target_word    = cur_req.w;

    mips_rel_relocation_patch #(
        .STACK_DEPTH(HI_DEPTH)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_section_start  (i_section_start),
        .i_reloc_type     (i_reloc_type),
        .i_symbol_index   (i_symbol_index),
        .i_symbol_section (i_symbol_section),
        .i_section_base   (i_section_base),
        .i_symbol_offset  (i_symbol_offset),
        .i_target_address (i_target_address),
        .i_target_word    (i_target_word),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_write_valid    (o_write_valid),
        .o_write_address  (o_write_address),
        .o_write_data     (o_write_data),
        .o_status         (o_status),
        .o_last           (o_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Patch predictor
    // ---------------------------------------------------------------
    task automatic queue_write(input logic wv, input logic [31:0] addr,
                               input logic [31:0] data, input logic [2:0] st,
                               input logic last);
        t_result r;
        r.wv     = wv;
        r.addr   = wv ? addr : '0;
        r.data   = wv ? data : '0;
        r.status = st;
        r.last   = last;
        patched_words.push_back(r);
    endtask

    task automatic apply_relocation(input t_reloc_req r);
        logic [31:0] s, v, tgt, lo, sum, d, sh, rel, hw;
        logic [15:0] hi;
        int t;
        s = r.base + r.offs;
        v = s + addr_adjust;
        if (r.start) begin
            hi_level = 0;
            for (int i = 0; i < HI_DEPTH; i++) hi_open[i] = 1'b0;
        end
        // symbol check comes first for every type
        if (r.sym >= {8'h00, sym_limit} || r.shndx == SECT_UNDEFINED
            || r.shndx == SECT_COMMON) begin
            queue_write(1'b0, '0, '0, ST_BAD_SYM, 1'b1);
            return;
        end
        case (r.rtype)
            RT_NONE: queue_write(1'b0, '0, '0, ST_OK, 1'b1);
            RT_32:   queue_write(1'b1, r.p, r.w + v, ST_OK, 1'b1);
            RT_26: begin
                tgt = r.p + addr_adjust + JUMP_STEP;
                if (v[1:0] != 2'b00 || v[31:28] != tgt[31:28]) begin
                    queue_write(1'b0, '0, '0, ST_BAD_JUMP, 1'b1);
                end else begin
                    sum = r.w + (v >> 2);
                    queue_write(1'b1, r.p, {r.w[31:26], sum[25:0]}, ST_OK, 1'b1);
                end
            end
            RT_HI16: begin
                if (hi_level >= HI_DEPTH) begin
                    queue_write(1'b0, '0, '0, ST_BAD_PAIR, 1'b1);
                end else begin
                    hi_loc[hi_level]  = r.p;
                    hi_sym[hi_level]  = s;
                    hi_word[hi_level] = r.w;
                    hi_open[hi_level] = 1'b1;
                    hi_level++;
                    queue_write(1'b0, '0, '0, ST_OK, 1'b1);
                end
            end
            RT_LO16: begin
                lo = {{16{r.w[15]}}, r.w[15:0]};
                if (hi_level > 0) begin
                    t = hi_level - 1;
                    hi_level = t;
                    if (hi_open[t]) begin
                        hi_open[t] = 1'b0;
                        if (hi_sym[t] != s) begin
                            queue_write(1'b0, '0, '0, ST_BAD_PAIR, 1'b1);
                            return;
                        end
                        // HI16 word first, upper half rounded by the LO16 carry
                        hw  = hi_word[t];
                        sum = {hw[15:0], 16'h0000} + lo + v;
                        hi  = sum[31:16] + {15'h0000, sum[15]};
                        queue_write(1'b1, hi_loc[t], {hw[31:16], hi}, ST_OK, 1'b0);
                    end
                end
                sum = v + lo;
                queue_write(1'b1, r.p, {r.w[31:16], sum[15:0]}, ST_OK, 1'b1);
            end
            RT_PC16: begin
                d   = s - r.p;
                sh  = $signed(d) >>> 2;
                rel = sh - 32'd1;
                sum = rel + 32'h0000_8000;
                if (sum >= 32'h0001_0000)
                    queue_write(1'b0, '0, '0, ST_PC16_RNG, 1'b1);
                else
                    queue_write(1'b1, r.p, {r.w[31:16], rel[15:0]}, ST_OK, 1'b1);
            end
            default: queue_write(1'b0, '0, '0, ST_BAD_TYPE, 1'b1);
        endcase
    endtask

    // ---------------------------------------------------------------
    // Entry builders
    // ---------------------------------------------------------------
    function automatic logic [23:0] pick_symbol();
        if (sym_limit == 0) return 24'($urandom_range(0, 16'hffff));
        if ($urandom_range(0, 15) == 0) return 24'(sym_limit - 1);
        return 24'($urandom_range(0, sym_limit - 1));
    endfunction

    // Well-formed entry whose symbol sums to s_val
    function automatic t_reloc_req make_entry(input logic [7:0] rtype,
                                              input logic [31:0] s_val);
        t_reloc_req r;
        r.start = 1'b0;
        r.rtype = rtype;
        r.sym   = pick_symbol();
        r.shndx = 16'($urandom_range(1, 16'hffff));
        if (r.shndx == SECT_COMMON) r.shndx = 16'h0001;
        r.base  = $urandom;
        r.offs  = s_val - r.base;
        r.p     = $urandom;
        r.w     = $urandom;
        return r;
    endfunction

    function automatic t_reloc_req jump_entry(input bit aligned, input bit same_region);
        t_reloc_req r;
        logic [31:0] tgt, vv;
        r   = make_entry(RT_26, 32'h0);
        tgt = r.p + addr_adjust + JUMP_STEP;
        vv  = $urandom;
        vv[31:28] = same_region ? tgt[31:28] : ~tgt[31:28];
        if (aligned) vv[1:0] = 2'b00;
        else if (vv[1:0] == 2'b00) vv[1:0] = 2'b01;
        r.offs = vv - addr_adjust - r.base;
        return r;
    endfunction

    // PC16 entry whose word offset works out to relv
    function automatic t_reloc_req pc16_entry(input int relv);
        t_reloc_req r;
        logic [31:0] span;
        r    = make_entry(RT_PC16, 32'h0);
        span = (relv + 1) * 4 + $urandom_range(0, 3);
        r.offs = r.p + span - r.base;
        return r;
    endfunction

    task automatic push_entry(input t_reloc_req r);
        reloc_entries.push_back(r);
        queued_cnt++;
    endtask

    // One random sequence: singles, HI16/LO16 groups, lone LO16s, overflow bursts, bad symbols, noise
    task automatic add_sequence();
        int kind, k, nlo, idx, relv;
        logic [31:0] sv [4];
        logic [31:0] sval;
        t_reloc_req e;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            case ($urandom_range(0, 5))
                0: e = make_entry(RT_NONE, $urandom);
                1: e = make_entry(RT_32, $urandom);
                2, 3: e = jump_entry($urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
                default: begin
                    case ($urandom_range(0, 4))
                        0: relv = 32768 + $urandom_range(0, 1 << 20);
                        1: relv = -32769 - int'($urandom_range(0, 1 << 20));
                        default: relv = int'($urandom_range(0, 65535)) - 32768;
                    endcase
                    e = pc16_entry(relv);
                end
            endcase
            e.start = ($urandom_range(0, 31) == 0);
            push_entry(e);
        end else if (kind < 60) begin
            // nested HI16s, then LO16s popping them in reverse
            k   = $urandom_range(1, 4);
            nlo = k;
            case ($urandom_range(0, 9))
                0: nlo = k - 1;
                1: nlo = k + 1;
                default: ;
            endcase
            for (int i = 0; i < k; i++) begin
                sv[i] = $urandom;
                e = make_entry(RT_HI16, sv[i]);
                e.start = (i == 0) && ($urandom_range(0, 3) == 0);
                push_entry(e);
            end
            for (int j = 0; j < nlo; j++) begin
                idx  = k - 1 - j;
                sval = (idx >= 0) ? sv[idx] : $urandom;
                if ($urandom_range(0, 9) == 0) sval = sval + 1;
                push_entry(make_entry(RT_LO16, sval));
            end
        end else if (kind < 68) begin
            // LO16 with nothing pending
            e = make_entry(RT_LO16, $urandom);
            e.start = 1'b1;
            push_entry(e);
        end else if (kind < 72) begin
            // more HI16s than the stack holds
            sval = $urandom;
            k = $urandom_range(HI_DEPTH + 1, HI_DEPTH + 3);
            for (int i = 0; i < k; i++) begin
                e = make_entry(RT_HI16, sval);
                e.start = (i == 0);
                push_entry(e);
            end
            k = $urandom_range(1, 3);
            for (int i = 0; i < k; i++) push_entry(make_entry(RT_LO16, sval));
        end else if (kind < 85) begin
            e = make_entry(RT_NONE, $urandom);
            case ($urandom_range(0, 5))
                0: e.rtype = RT_NONE;
                1: e.rtype = RT_32;
                2: e.rtype = RT_26;
                3: e.rtype = RT_HI16;
                4: e.rtype = RT_LO16;
                default: e.rtype = RT_PC16;
            endcase
            case ($urandom_range(0, 2))
                0: e.sym = 24'({8'h00, sym_limit} + $urandom_range(0, 1000));
                1: e.shndx = SECT_UNDEFINED;
                default: e.shndx = SECT_COMMON;
            endcase
            push_entry(e);
        end else begin
            e.start = 1'($urandom);
            e.rtype = 8'($urandom);
            e.sym   = $urandom_range(0, 1) ? 24'($urandom) : pick_symbol();
            e.shndx = 16'($urandom);
            e.base  = $urandom;
            e.offs  = $urandom;
            e.p     = $urandom;
            e.w     = $urandom;
            push_entry(e);
        end
    endtask

    // ---------------------------------------------------------------
    // Phase control
    // ---------------------------------------------------------------
    task automatic wait_drained();
        while (reloc_entries.size() != 0 || tx_busy || patched_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] adj, input logic [15:0] cnt);
        logic [15:0] junk;
        junk = 16'($urandom);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ADDR_ADJUST;
        i_cfg_data  <= adj;
        @(negedge i_clk);
        i_cfg_index <= CFG_SYM_COUNT;
        i_cfg_data  <= {junk, cnt};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        addr_adjust = adj;
        sym_limit   = cnt;
    endtask

    task automatic run_phase(input logic [31:0] adj, input logic [15:0] cnt,
                             input int n, input bit hold);
        int target;
        program_regs(adj, cnt);
        if (hold) hold_req_cnt++;
        target = queued_cnt + n / 2;
        while (queued_cnt < target) add_sequence();
        // sender pauses until every write is back
        wait_drained();
        target = queued_cnt + n - n / 2;
        while (queued_cnt < target) add_sequence();
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (tx_busy && accepted_cnt != tx_done_cnt) begin
                tx_done_cnt = accepted_cnt;
                tx_busy = 1'b0;
                tx_gap  = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (reloc_entries.size() != 0) begin
                    cur_req = reloc_entries.pop_front();
                    tx_busy = 1'b1;
                end
            end
            i_in_valid <= tx_busy;
        end
    end

    // Write receiver: per-write stall plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (results_cnt != rx_seen_cnt) begin
            rx_seen_cnt = results_cnt;
            rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        end
        if (hold_req_cnt != hold_done_cnt) begin
            hold_done_cnt = hold_req_cnt;
            rx_hold = LONG_HOLD;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on accepted requests, check accepted writes
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                apply_relocation(cur_req);
                accepted_cnt++;
            end
            if (o_out_valid && i_out_ready) begin
                results_cnt++;
                if (patched_words.size() == 0) begin
                    $error("write request with none pending: address %h data %h status %0d",
                           o_write_address, o_write_data, o_status);
                    fail_cnt++;
                end else begin
                    want = patched_words.pop_front();
                    if (o_write_valid !== want.wv) begin
                        $error("write_valid: expected %0d, actual %0d", want.wv, o_write_valid);
                        fail_cnt++;
                    end
                    if (o_write_address !== want.addr) begin
                        $error("write_address: expected %h, actual %h",
                               want.addr, o_write_address);
                        fail_cnt++;
                    end
                    if (o_write_data !== want.data) begin
                        $error("write_data: expected %h, actual %h", want.data, o_write_data);
                        fail_cnt++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        fail_cnt++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, o_last);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        t_reloc_req e;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every type, each check, pairing cases
        program_regs(32'h1000_0000, 16'd100);
        push_entry(make_entry(RT_NONE, 32'h0040_0000));
        e = make_entry(RT_32, 32'hffff_ffff);
        e.w = 32'hffff_ffff;
        push_entry(e);
        push_entry(jump_entry(1'b1, 1'b1));
        push_entry(jump_entry(1'b0, 1'b1));
        push_entry(jump_entry(1'b1, 1'b0));
        // matched pair with negative low half
        e = make_entry(RT_HI16, 32'h1234_8000);
        e.start = 1'b1;
        e.w = 32'h3c01_7fff;
        push_entry(e);
        e = make_entry(RT_LO16, 32'h1234_8000);
        e.w = 32'h2421_8000;
        push_entry(e);
        // symbol mismatch on the pop, then LO16 with an empty stack
        push_entry(make_entry(RT_HI16, 32'h0000_0000));
        push_entry(make_entry(RT_LO16, 32'h0000_0004));
        e = make_entry(RT_LO16, 32'hffff_ffff);
        e.w = 32'hffff_ffff;
        push_entry(e);
        // PC16 range edges
        push_entry(pc16_entry(32767));
        push_entry(pc16_entry(-32768));
        push_entry(pc16_entry(32768));
        push_entry(pc16_entry(-32769));
        // unknown types
        push_entry(make_entry(8'hff, 32'h0));
        push_entry(make_entry(8'h01, $urandom));
        // bad symbols: index at the count, largest index, undefined, common
        e = make_entry(RT_32, $urandom);
        e.sym = 24'd100;
        push_entry(e);
        e.sym = 24'hff_ffff;
        push_entry(e);
        e = make_entry(RT_LO16, $urandom);
        e.shndx = SECT_UNDEFINED;
        push_entry(e);
        e = make_entry(RT_HI16, $urandom);
        e.shndx = SECT_COMMON;
        push_entry(e);
        // last valid symbol in the top section index
        e = make_entry(RT_32, 32'h0);
        e.sym = 24'd99;
        e.shndx = 16'hffff;
        push_entry(e);
        // section start drops pending HI16s
        push_entry(make_entry(RT_HI16, 32'h0000_1000));
        push_entry(make_entry(RT_HI16, 32'h0000_1000));
        e = make_entry(RT_LO16, 32'h0000_1000);
        e.start = 1'b1;
        push_entry(e);
        wait_drained();

        // random phases over several register settings
        run_phase(32'h0000_0000, 16'hffff, 300, 1'b0);
        run_phase(32'hffff_ffff, 16'd1, 250, 1'b1);
        run_phase($urandom, 16'($urandom_range(2, 16'hffff)), 300, 1'b0);
        run_phase(32'h8000_0000, 16'd0, 60, 1'b0);
        run_phase($urandom, 16'hffff, 350, 1'b1);
        run_phase($urandom, 16'($urandom_range(1, 300)), 400, 1'b0);

        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
